@@ design/ctl_pkg.sv @@
// Shared constants for the closed tour length block.
// No dependencies; used by ctl_leg and closed_tour_length.
package ctl_pkg;

  // Default coordinate width of one tour point.
  localparam int COORD_BITS_DEF = 12;

  // Default width of the saturating tour length total.
  localparam int TOTAL_BITS_DEF = 32;

endpackage

@@ design/ctl_leg.sv @@
// Leg length unit: floor(sqrt(dx*dx + dy*dy)) between two points.
// One shared multiplier squares both deltas, then a restoring square root
// finds one root bit per cycle. Depends on ctl_pkg.
module ctl_leg #(
  parameter int COORD_BITS = ctl_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] ax,
  input  logic [COORD_BITS-1:0] ay,
  input  logic [COORD_BITS-1:0] bx,
  input  logic [COORD_BITS-1:0] by,
  output logic                  done,
  output logic [COORD_BITS:0]   leg
);

  // Root width, radicand width and iteration counter width.
  localparam int RootBits = COORD_BITS + 1;
  localparam int RadBits  = 2 * RootBits;
  localparam int CntBits  = $clog2(RootBits);

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_SQX  = 2'd1;
  localparam logic [1:0] L_SUM  = 2'd2;
  localparam logic [1:0] L_ROOT = 2'd3;

  logic [1:0]              phase_r, phase_nxt;
  logic [COORD_BITS-1:0]   dx_r, dx_nxt;
  logic [COORD_BITS-1:0]   dy_r, dy_nxt;
  logic [2*COORD_BITS-1:0] sq_r, sq_nxt;
  logic [RadBits-1:0]      rad_r, rad_nxt;
  logic [RootBits-1:0]     rem_r, rem_nxt;
  logic [RootBits-1:0]     root_r, root_nxt;
  logic [CntBits-1:0]      cnt_r, cnt_nxt;
  logic                    done_r, done_nxt;

  logic [COORD_BITS-1:0]   mul_a;
  logic [2*COORD_BITS-1:0] mul_p;
  logic [RootBits+1:0]     rem_sh;
  logic [RootBits+1:0]     trial;
  logic [RootBits+1:0]     rem_sub;
  logic                    fits;

  // The one multiplier squares dx first, then dy.
  assign mul_a = (phase_r == L_SQX) ? dx_r : dy_r;
  assign mul_p = mul_a * mul_a;

  // One restoring square root step: bring down two radicand bits, try 4r+1.
  assign rem_sh  = {rem_r, rad_r[RadBits-1 -: 2]};
  assign trial   = {1'b0, root_r[RootBits-2:0], 2'b01};
  assign fits    = (rem_sh >= trial);
  assign rem_sub = rem_sh - trial;

  always_comb begin
    phase_nxt = phase_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    sq_nxt    = sq_r;
    rad_nxt   = rad_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    case (phase_r)
      L_IDLE: begin
        if (start) begin
          dx_nxt    = (ax >= bx) ? ax - bx : bx - ax;
          dy_nxt    = (ay >= by) ? ay - by : by - ay;
          phase_nxt = L_SQX;
        end
      end
      L_SQX: begin
        sq_nxt    = mul_p;
        phase_nxt = L_SUM;
      end
      L_SUM: begin
        rad_nxt   = RadBits'(sq_r) + RadBits'(mul_p);
        rem_nxt   = '0;
        root_nxt  = '0;
        cnt_nxt   = '0;
        phase_nxt = L_ROOT;
      end
      L_ROOT: begin
        rad_nxt  = {rad_r[RadBits-3:0], 2'b00};
        rem_nxt  = fits ? rem_sub[RootBits-1:0] : rem_sh[RootBits-1:0];
        root_nxt = {root_r[RootBits-2:0], fits};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CntBits'(RootBits - 1)) begin
          done_nxt  = 1'b1;
          phase_nxt = L_IDLE;
        end
      end
      default: begin
        phase_nxt = L_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    sq_r   <= sq_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign leg  = root_r;

endmodule

@@ design/closed_tour_length.sv @@
// Closed tour length: the top level, with the tour sequencer and the total.
// Instantiates ctl_leg; takes defaults from ctl_pkg.
//
// Points of a tour arrive one per beat, x and y in in_tdata and the final
// point marked by in_tlast. Every point but the first runs one leg through
// the shared leg unit: it squares dx and then dy, finds one root bit per
// cycle, and adds the leg into the total. The final point runs a second leg
// back to the start, and the total then goes to the result register. The
// block takes no new point while a leg is in flight, and once a tour's
// total is ready it takes no further point until the previous result has
// been taken. The total saturates at 2^TOTAL_BITS - 1; a one-point tour
// reports 0.
module closed_tour_length #(
  parameter int COORD_BITS = ctl_pkg::COORD_BITS_DEF,
  parameter int TOTAL_BITS = ctl_pkg::TOTAL_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // point_x, point_y, zero padding
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  // last_point
  input  logic                                  in_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // tour_length, zero padding
  output logic [((TOTAL_BITS+7)/8)*8-1:0]       out_tdata
);

  localparam int OutBits = ((TOTAL_BITS + 7) / 8) * 8;
  localparam int LegBits = COORD_BITS + 1;
  localparam int SumBits = ((TOTAL_BITS > LegBits) ? TOTAL_BITS : LegBits) + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LEG   = 2'd1;
  localparam logic [1:0] S_CLOSE = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic                  started_r, started_nxt;
  logic                  last_r, last_nxt;
  logic [COORD_BITS-1:0] start_x_r, start_x_nxt;
  logic [COORD_BITS-1:0] start_y_r, start_y_nxt;
  logic [COORD_BITS-1:0] prev_x_r, prev_x_nxt;
  logic [COORD_BITS-1:0] prev_y_r, prev_y_nxt;
  logic [TOTAL_BITS-1:0] total_r, total_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [TOTAL_BITS-1:0] out_len_r, out_len_nxt;

  logic [COORD_BITS-1:0] pt_x;
  logic [COORD_BITS-1:0] pt_y;
  logic                  in_beat;
  logic                  leg_start;
  logic [COORD_BITS-1:0] leg_ax, leg_ay, leg_bx, leg_by;
  logic                  leg_done;
  logic [LegBits-1:0]    leg_len;
  logic [SumBits-1:0]    sum;
  logic [TOTAL_BITS-1:0] sat_sum;

  assign pt_x = in_tdata[COORD_BITS-1:0];
  assign pt_y = in_tdata[2*COORD_BITS-1:COORD_BITS];

  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;

  // Saturating add of the finished leg into the running total.
  assign sum     = SumBits'(total_r) + SumBits'(leg_len);
  assign sat_sum = (sum[SumBits-1:TOTAL_BITS] != '0) ? '1 : sum[TOTAL_BITS-1:0];

  // A leg starts from the previous point on a non-first beat, or closes
  // from the final point back to the start once the last inner leg is in.
  assign leg_start = (in_beat && started_r) || (state_r == S_LEG && leg_done && last_r);
  assign leg_ax    = (state_r == S_IDLE) ? prev_x_r : prev_x_r;
  assign leg_ay    = prev_y_r;
  assign leg_bx    = (state_r == S_IDLE) ? pt_x : start_x_r;
  assign leg_by    = (state_r == S_IDLE) ? pt_y : start_y_r;

  ctl_leg #(
    .COORD_BITS(COORD_BITS)
  ) u_leg (
    .clk  (clk),
    .rst_n(rst_n),
    .start(leg_start),
    .ax   (leg_ax),
    .ay   (leg_ay),
    .bx   (leg_bx),
    .by   (leg_by),
    .done (leg_done),
    .leg  (leg_len)
  );

  // Tour sequencer.
  always_comb begin
    state_nxt     = state_r;
    started_nxt   = started_r;
    last_nxt      = last_r;
    start_x_nxt   = start_x_r;
    start_y_nxt   = start_y_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_len_nxt   = out_len_r;
    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          last_nxt   = in_tlast;
          prev_x_nxt = pt_x;
          prev_y_nxt = pt_y;
          if (!started_r) begin
            start_x_nxt = pt_x;
            start_y_nxt = pt_y;
            total_nxt   = '0;
            started_nxt = 1'b1;
            state_nxt   = in_tlast ? S_EMIT : S_IDLE;
          end else begin
            state_nxt = S_LEG;
          end
        end
      end
      S_LEG: begin
        if (leg_done) begin
          total_nxt = sat_sum;
          state_nxt = last_r ? S_CLOSE : S_IDLE;
        end
      end
      S_CLOSE: begin
        if (leg_done) begin
          total_nxt = sat_sum;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_len_nxt   = total_r;
          out_valid_nxt = 1'b1;
          started_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      start_x_r   <= '0;
      start_y_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      total_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      start_x_r   <= start_x_nxt;
      start_y_r   <= start_y_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      total_r     <= total_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    last_r    <= last_nxt;
    out_len_r <= out_len_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OutBits'(out_len_r);

endmodule
